// File: src/pr2d_pkg.sv
// Shared constants, types and the sine/cosine table function for the point rotator.
`default_nettype none

package pr2d_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_ANGLE_WIDTH = 16;

  localparam int HALF_TURN_DEG  = 180;
  localparam int STEPS_PER_DEG  = 64;
  localparam int QUARTER_STEPS  = HALF_TURN_DEG * STEPS_PER_DEG / 2;
  localparam int FULL_STEPS     = 4 * QUARTER_STEPS;
  localparam int OCTANT_STEPS   = QUARTER_STEPS / 2;
  localparam int SUB_SHIFT      = 7;
  localparam int SUB_DIV        = QUARTER_STEPS >> SUB_SHIFT;
  localparam int DIV_BITS       = $clog2(SUB_DIV);
  localparam int M_W            = DIV_BITS + SUB_SHIFT;
  localparam int TRIG_DEN       = HALF_TURN_DEG * STEPS_PER_DEG * 16;

  localparam logic [63:0] PI_Q34   = 64'h0000_000C_90FD_AA22;
  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF = 64'd1 << 29;
  localparam int          FRAC_BITS = 30;

  localparam int TRIG_W    = 31;
  localparam int COEF_W    = 32;
  localparam int ROM_DEPTH = OCTANT_STEPS + 1;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);

  localparam int SC_STAGES  = 4;
  localparam int ROT_STAGES = 4;
  localparam int PIPE_DEPTH = SC_STAGES + ROT_STAGES;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } pr2d_quad_e;

  typedef struct packed {
    logic [TRIG_W-1:0] c;
    logic [TRIG_W-1:0] s;
  } trig_pair_t;

  function automatic logic [63:0] qmul_f(input logic [63:0] a, input logic [63:0] b);
    return (a * b + Q30_HALF) >> FRAC_BITS;
  endfunction

  // Q30 cosine and sine of m steps of 1/64 degree, m within one octant.
  function automatic trig_pair_t sincos_f(input logic [ROM_AW-1:0] m);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] p;
    logic [63:0] s;
    trig_pair_t r;
    t = (64'(m) * PI_Q34 + 64'(TRIG_DEN / 2)) / 64'(TRIG_DEN);
    u = qmul_f(t, t);
    p = Q30_ONE;
    p = Q30_ONE - (qmul_f(u, p) + 64'd78) / 64'd156;
    p = Q30_ONE - (qmul_f(u, p) + 64'd55) / 64'd110;
    p = Q30_ONE - (qmul_f(u, p) + 64'd36) / 64'd72;
    p = Q30_ONE - (qmul_f(u, p) + 64'd21) / 64'd42;
    p = Q30_ONE - (qmul_f(u, p) + 64'd10) / 64'd20;
    p = Q30_ONE - (qmul_f(u, p) + 64'd3) / 64'd6;
    s = qmul_f(t, p);
    p = Q30_ONE;
    p = Q30_ONE - (qmul_f(u, p) + 64'd91) / 64'd182;
    p = Q30_ONE - (qmul_f(u, p) + 64'd66) / 64'd132;
    p = Q30_ONE - (qmul_f(u, p) + 64'd45) / 64'd90;
    p = Q30_ONE - (qmul_f(u, p) + 64'd28) / 64'd56;
    p = Q30_ONE - (qmul_f(u, p) + 64'd15) / 64'd30;
    p = Q30_ONE - (qmul_f(u, p) + 64'd6) / 64'd12;
    p = Q30_ONE - (qmul_f(u, p) + 64'd1) / 64'd2;
    r.c = p[TRIG_W-1:0];
    r.s = s[TRIG_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/point_rotation_2d_top.sv
// Top level of the 2-D point rotator: stream ports, stage valid chain and coordinate delay line.
//
// Rotates each point (x, y) counter-clockwise about the origin by an angle given in 1/64
// degree, any value reduced modulo 360 degrees; coordinates are signed Q16.16 and results
// saturate to the coordinate range with the overflow flag set in tuser. The block is an
// eight-stage pipeline that takes a new beat every cycle while it is not full and stalled. Four
// stages reduce the angle and read a 2881-entry octant table of cosine and sine through its
// registered port; four more form the split products, combine them, round and saturate.
// Every stage holds its own valid bit and fills bubbles while the output is stalled, so
// input ready drops only when all eight stages are full and the output beat is not taken.
`default_nettype none

module point_rotation_2d_top #(
  parameter  int COORD_WIDTH = pr2d_pkg::DEF_COORD_WIDTH,
  parameter  int ANGLE_WIDTH = pr2d_pkg::DEF_ANGLE_WIDTH,
  localparam int IN_DW       = ((2 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW      = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // x_in, y_in, angle
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // x_out, y_out
  output logic [0:0]        m_axis_tuser    // overflow
);
  import pr2d_pkg::*;

  logic [PIPE_DEPTH-1:0] v_d, v_q, en;

  always_comb begin
    en[PIPE_DEPTH-1] = !v_q[PIPE_DEPTH-1] || m_axis_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = {v_q[PIPE_DEPTH-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  logic signed [COORD_WIDTH-1:0] x_in, y_in;
  logic signed [ANGLE_WIDTH-1:0] angle;

  assign x_in  = s_axis_tdata[COORD_WIDTH-1:0];
  assign y_in  = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign angle = s_axis_tdata[2*COORD_WIDTH+ANGLE_WIDTH-1:2*COORD_WIDTH];

  // hold coordinates alongside the angle stages
  logic [COORD_WIDTH-1:0] x_d [SC_STAGES];
  logic [COORD_WIDTH-1:0] x_q [SC_STAGES];
  logic [COORD_WIDTH-1:0] y_d [SC_STAGES];
  logic [COORD_WIDTH-1:0] y_q [SC_STAGES];

  always_comb begin
    x_d[0] = x_in;
    y_d[0] = y_in;
    for (int k = 1; k < SC_STAGES; k++) begin
      x_d[k] = x_q[k-1];
      y_d[k] = y_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SC_STAGES; k++) begin
      if (en[k]) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
      end
    end
  end

  logic signed [COEF_W-1:0]      cos_c, sin_c;
  logic signed [COORD_WIDTH-1:0] x_out, y_out;
  logic                          overflow;

  pr2d_sincos #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_sincos (
    .clk_i  (clk_i),
    .en_i   (en[SC_STAGES-1:0]),
    .angle_i(angle),
    .cos_o  (cos_c),
    .sin_o  (sin_c)
  );

  pr2d_rot #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_rot (
    .clk_i(clk_i),
    .en_i (en[PIPE_DEPTH-1:SC_STAGES]),
    .x_i  (signed'(x_q[SC_STAGES-1])),
    .y_i  (signed'(y_q[SC_STAGES-1])),
    .cos_i(cos_c),
    .sin_i(sin_c),
    .x_o  (x_out),
    .y_o  (y_out),
    .ovf_o(overflow)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[PIPE_DEPTH-1];
  assign m_axis_tdata  = OUT_DW'({y_out, x_out});
  assign m_axis_tuser  = overflow;

endmodule

`default_nettype wire

// File: src/pr2d_sincos.sv
// Angle reduction, octant table lookup and quadrant mapping to signed Q30 cosine and sine.
`default_nettype none

module pr2d_sincos #(
  parameter int ANGLE_WIDTH = pr2d_pkg::DEF_ANGLE_WIDTH
) (
  input  logic                                clk_i,
  input  logic [pr2d_pkg::SC_STAGES-1:0]      en_i,
  input  logic signed [ANGLE_WIDTH-1:0]       angle_i,
  output logic signed [pr2d_pkg::COEF_W-1:0]  cos_o,
  output logic signed [pr2d_pkg::COEF_W-1:0]  sin_o
);
  import pr2d_pkg::*;

  localparam int OFFSET  = ((2 ** (ANGLE_WIDTH - 1) + FULL_STEPS - 1) / FULL_STEPS) * FULL_STEPS;
  localparam int UW      = $clog2(OFFSET + 2 ** (ANGLE_WIDTH - 1));
  localparam int VW      = UW - SUB_SHIFT;
  localparam int SH      = VW + DIV_BITS;
  localparam int RECIP_W = VW + 1;
  localparam int QW      = VW - DIV_BITS + 1;
  localparam int PROD_W  = VW + RECIP_W;
  localparam longint unsigned RECIP = (longint'(1) << SH) / SUB_DIV;

  trig_pair_t rom [ROM_DEPTH];

  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    assign rom[i] = sincos_f(ROM_AW'(i));
  end

  // stage 1
  logic [UW-1:0]        u;
  logic [PROD_W-1:0]    prod_d, prod_q;
  logic [VW-1:0]        sub_d, sub_q;
  logic [SUB_SHIFT-1:0] ulo_d, ulo_q;

  always_comb begin
    u      = UW'(OFFSET) + UW'(angle_i);
    sub_d  = u[UW-1:SUB_SHIFT];
    ulo_d  = u[SUB_SHIFT-1:0];
    prod_d = PROD_W'(sub_d) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      sub_q  <= sub_d;
      ulo_q  <= ulo_d;
    end
  end

  // stage 2
  logic [QW-1:0]     q0;
  logic [VW-1:0]     q45;
  logic [VW-1:0]     rem;
  logic [VW-1:0]     remc;
  logic              fix;
  logic [M_W-1:0]    m;
  logic              swap_d, swap_q2;
  logic [ROM_AW-1:0] addr_d, addr_q;
  pr2d_quad_e        quad_d, quad_q2;

  always_comb begin
    q0     = prod_q[SH +: QW];
    q45    = VW'(q0) * VW'(SUB_DIV);
    rem    = sub_q - q45;
    fix    = rem >= VW'(SUB_DIV);
    remc   = fix ? rem - VW'(SUB_DIV) : rem;
    quad_d = pr2d_quad_e'(q0[1:0] + {1'b0, fix});
    m      = {remc[DIV_BITS-1:0], ulo_q};
    swap_d = m > M_W'(OCTANT_STEPS);
    addr_d = swap_d ? ROM_AW'(M_W'(QUARTER_STEPS) - m) : ROM_AW'(m);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      addr_q  <= addr_d;
      swap_q2 <= swap_d;
      quad_q2 <= quad_d;
    end
  end

  // stage 3
  trig_pair_t rom_q;
  logic       swap_q3;
  pr2d_quad_e quad_q3;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      rom_q   <= rom[addr_q];
      swap_q3 <= swap_q2;
      quad_q3 <= quad_q2;
    end
  end

  // stage 4
  logic signed [COEF_W-1:0] cp, sp;
  logic signed [COEF_W-1:0] cos_d, cos_q, sin_d, sin_q;

  always_comb begin
    cp = signed'({{(COEF_W - TRIG_W){1'b0}}, swap_q3 ? rom_q.s : rom_q.c});
    sp = signed'({{(COEF_W - TRIG_W){1'b0}}, swap_q3 ? rom_q.c : rom_q.s});
    case (quad_q3)
      QUAD_0: begin
        cos_d = cp;
        sin_d = sp;
      end
      QUAD_1: begin
        cos_d = -sp;
        sin_d = cp;
      end
      QUAD_2: begin
        cos_d = -cp;
        sin_d = -sp;
      end
      QUAD_3: begin
        cos_d = sp;
        sin_d = -cp;
      end
      default: begin
        cos_d = cp;
        sin_d = sp;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire

// File: src/pr2d_rot.sv
// Split-operand rotation products, exact Q30 rounding and saturation of both coordinates.
`default_nettype none

module pr2d_rot #(
  parameter int COORD_WIDTH = pr2d_pkg::DEF_COORD_WIDTH
) (
  input  logic                                clk_i,
  input  logic [pr2d_pkg::ROT_STAGES-1:0]     en_i,
  input  logic signed [COORD_WIDTH-1:0]       x_i,
  input  logic signed [COORD_WIDTH-1:0]       y_i,
  input  logic signed [pr2d_pkg::COEF_W-1:0]  cos_i,
  input  logic signed [pr2d_pkg::COEF_W-1:0]  sin_i,
  output logic signed [COORD_WIDTH-1:0]       x_o,
  output logic signed [COORD_WIDTH-1:0]       y_o,
  output logic                                ovf_o
);
  import pr2d_pkg::*;

  localparam int LO_W  = COORD_WIDTH / 2;
  localparam int HI_W  = COORD_WIDTH - LO_W;
  localparam int PH_W  = HI_W + COEF_W;
  localparam int PL_W  = LO_W + 1 + COEF_W;
  localparam int DH_W  = PH_W + 1;
  localparam int DL_W  = PL_W + 1;
  localparam int SUM_W = COORD_WIDTH + COEF_W + 1;
  localparam int RES_W = SUM_W - FRAC_BITS;
  localparam int TOP_W = RES_W - COORD_WIDTH + 1;

  // stage 1: partial products
  logic signed [LO_W:0]     xl, yl;
  logic signed [HI_W-1:0]   xh, yh;
  logic signed [PH_W-1:0]   xc_h_d, ys_h_d, xs_h_d, yc_h_d;
  logic signed [PH_W-1:0]   xc_h_q, ys_h_q, xs_h_q, yc_h_q;
  logic signed [PL_W-1:0]   xc_l_d, ys_l_d, xs_l_d, yc_l_d;
  logic signed [PL_W-1:0]   xc_l_q, ys_l_q, xs_l_q, yc_l_q;

  always_comb begin
    xl     = signed'({1'b0, x_i[LO_W-1:0]});
    yl     = signed'({1'b0, y_i[LO_W-1:0]});
    xh     = x_i[COORD_WIDTH-1:LO_W];
    yh     = y_i[COORD_WIDTH-1:LO_W];
    xc_h_d = xh * cos_i;
    ys_h_d = yh * sin_i;
    xs_h_d = xh * sin_i;
    yc_h_d = yh * cos_i;
    xc_l_d = xl * cos_i;
    ys_l_d = yl * sin_i;
    xs_l_d = xl * sin_i;
    yc_l_d = yl * cos_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xc_h_q <= xc_h_d;
      ys_h_q <= ys_h_d;
      xs_h_q <= xs_h_d;
      yc_h_q <= yc_h_d;
      xc_l_q <= xc_l_d;
      ys_l_q <= ys_l_d;
      xs_l_q <= xs_l_d;
      yc_l_q <= yc_l_d;
    end
  end

  // stage 2: combine halves, add rounding constant to the low part
  logic signed [DH_W-1:0] dxh_d, dxh_q, dyh_d, dyh_q;
  logic signed [DL_W-1:0] dxl_d, dxl_q, dyl_d, dyl_q;

  always_comb begin
    dxh_d = DH_W'(xc_h_q) - DH_W'(ys_h_q);
    dyh_d = DH_W'(xs_h_q) + DH_W'(yc_h_q);
    dxl_d = DL_W'(xc_l_q) - DL_W'(ys_l_q) + DL_W'(Q30_HALF);
    dyl_d = DL_W'(xs_l_q) + DL_W'(yc_l_q) + DL_W'(Q30_HALF);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dxh_q <= dxh_d;
      dyh_q <= dyh_d;
      dxl_q <= dxl_d;
      dyl_q <= dyl_d;
    end
  end

  // stage 3: full sum, floor shift
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [RES_W-1:0] rx_d, rx_q, ry_d, ry_q;

  always_comb begin
    sx   = (SUM_W'(dxh_q) <<< LO_W) + SUM_W'(dxl_q);
    sy   = (SUM_W'(dyh_q) <<< LO_W) + SUM_W'(dyl_q);
    rx_d = sx[SUM_W-1:FRAC_BITS];
    ry_d = sy[SUM_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  // stage 4: saturate
  localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic [TOP_W-1:0]       tx, ty;
  logic                   ox, oy;
  logic [COORD_WIDTH-1:0] xo_d, xo_q, yo_d, yo_q;
  logic                   ovf_d, ovf_q;

  always_comb begin
    tx    = rx_q[RES_W-1:COORD_WIDTH-1];
    ty    = ry_q[RES_W-1:COORD_WIDTH-1];
    ox    = !(&tx) && (|tx);
    oy    = !(&ty) && (|ty);
    xo_d  = ox ? (rx_q[RES_W-1] ? SAT_MIN : SAT_MAX) : rx_q[COORD_WIDTH-1:0];
    yo_d  = oy ? (ry_q[RES_W-1] ? SAT_MIN : SAT_MAX) : ry_q[COORD_WIDTH-1:0];
    ovf_d = ox || oy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      xo_q  <= xo_d;
      yo_q  <= yo_d;
      ovf_q <= ovf_d;
    end
  end

  assign x_o   = signed'(xo_q);
  assign y_o   = signed'(yo_q);
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

// File: src/pr2d_checker.sv
// Port-level assertions for the point rotator and the bind that attaches them.
`default_nettype none

module pr2d_checker #(
  parameter  int COORD_WIDTH = pr2d_pkg::DEF_COORD_WIDTH,
  parameter  int ANGLE_WIDTH = pr2d_pkg::DEF_ANGLE_WIDTH,
  localparam int IN_DW       = ((2 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW      = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // x_in, y_in, angle
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_DW-1:0] m_axis_tdata,   // x_out, y_out
  input  logic [0:0]        m_axis_tuser    // overflow
);
  import pr2d_pkg::*;

  localparam int OCC_W = $clog2(PIPE_DEPTH + 1);
  localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic [OCC_W-1:0]       occ_d, occ_q;
  logic                   in_beat, out_beat;
  logic [COORD_WIDTH-1:0] xo, yo;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign occ_d    = occ_q + OCC_W'(in_beat) - OCC_W'(out_beat);
  assign xo       = m_axis_tdata[COORD_WIDTH-1:0];
  assign yo       = m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input beat changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (xo == SAT_MAX || xo == SAT_MIN || yo == SAT_MAX || yo == SAT_MIN))
    else $error("overflow flagged without a saturated coordinate");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |->
      m_axis_tvalid && !m_axis_tready && occ_q == OCC_W'(PIPE_DEPTH))
    else $error("input stalled while pipeline not full and blocked");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> occ_q != '0)
    else $error("output beat with no beat in flight");

endmodule

bind point_rotation_2d_top pr2d_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_pr2d_checker (.*);

`default_nettype wire

// File: bench/point_rotation_2d_top_tb.sv
// Self-checking stream testbench for the 2-D point rotator, with its own fixed-point predictor.
`timescale 1ns / 100ps

module point_rotation_2d_top_tb;
  import pr2d_pkg::*;

  localparam int     CW          = DEF_COORD_WIDTH;
  localparam int     AW          = DEF_ANGLE_WIDTH;
  localparam int     IN_W        = ((2 * CW + AW + 7) / 8) * 8;
  localparam int     OUT_W       = ((2 * CW + 7) / 8) * 8;
  localparam longint COORD_MAX   = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COORD_MIN   = -COORD_MAX - 1;
  localparam longint ROUND_HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam int     RANDOM_RUNS = 2;
  localparam int     RUN_POINTS  = 700;
  localparam int     HOLD_AT     = 300;
  localparam int     HOLD_CYCLES = 400;
  localparam int     MAX_REPORTS = 100;
  localparam int     CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic signed [AW-1:0] ang;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } point_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          ovf;
  } rotated_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0]       m_axis_tuser;

  point_t   points_todo[$];
  rotated_t rotated_due[$];
  point_t   point_on_bus;
  int       gap_left;
  int       send_calm;
  int       stall_left;
  int       recv_calm;
  int       hold_left;
  bit       hold_done;
  int       points_sent;
  int       beats_seen;
  int       bad_beats;
  int       saturated_seen;
  int       input_stall_cycles;
  int       cycle_cnt;
  int       directed_cnt;

  point_rotation_2d_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b + Q30_HALF) >> FRAC_BITS;
  endfunction

  // Q30 cosine and sine of the angle, by series on the folded octant angle.
  function automatic void unit_vector_q30(input logic signed [AW-1:0] ang,
                                          output longint cq, output longint sq);
    longint unsigned t;
    longint unsigned u;
    longint unsigned p;
    longint unsigned sn;
    longint unsigned cs;
    longint unsigned tmp;
    longint unsigned d;
    int              r;
    int              m;
    logic [1:0]      quad;
    bit              mirror;
    r = int'(ang) % FULL_STEPS;
    if (r < 0) r += FULL_STEPS;
    quad   = 2'(r / QUARTER_STEPS);
    m      = r % QUARTER_STEPS;
    mirror = m > QUARTER_STEPS / 2;
    if (mirror) m = QUARTER_STEPS - m;
    t = (longint'(m) * PI_Q34 + longint'(TRIG_DEN / 2)) / longint'(TRIG_DEN);
    u = q30_mul(t, t);
    p = Q30_ONE;
    for (int n = 12; n >= 2; n -= 2) begin
      d = longint'(n * (n + 1));
      p = Q30_ONE - (q30_mul(u, p) + d / 2) / d;
    end
    sn = q30_mul(t, p);
    p  = Q30_ONE;
    for (int n = 13; n >= 1; n -= 2) begin
      d = longint'(n * (n + 1));
      p = Q30_ONE - (q30_mul(u, p) + d / 2) / d;
    end
    cs = p;
    if (mirror) begin
      tmp = sn;
      sn  = cs;
      cs  = tmp;
    end
    case (pr2d_quad_e'(quad))
      QUAD_0: begin
        cq = longint'(cs);
        sq = longint'(sn);
      end
      QUAD_1: begin
        cq = -longint'(sn);
        sq = longint'(cs);
      end
      QUAD_2: begin
        cq = -longint'(cs);
        sq = -longint'(sn);
      end
      default: begin
        cq = longint'(sn);
        sq = -longint'(cs);
      end
    endcase
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input longint v, output bit hit);
    hit = 1'b0;
    if (v > COORD_MAX) begin
      hit = 1'b1;
      return COORD_MAX[CW-1:0];
    end
    if (v < COORD_MIN) begin
      hit = 1'b1;
      return COORD_MIN[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  function automatic rotated_t predict_rotation(input point_t pt);
    longint   xs;
    longint   ys;
    longint   cq;
    longint   sq;
    bit       hit_x;
    bit       hit_y;
    rotated_t res;
    xs = longint'(pt.x);
    ys = longint'(pt.y);
    unit_vector_q30(pt.ang, cq, sq);
    res.x   = clamp_coord((xs * cq - ys * sq + ROUND_HALF) >>> FRAC_BITS, hit_x);
    res.y   = clamp_coord((xs * sq + ys * cq + ROUND_HALF) >>> FRAC_BITS, hit_y);
    res.ovf = hit_x | hit_y;
    return res;
  endfunction

  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(40, 120);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [CW-1:0] random_coord();
    logic signed [CW-1:0] v;
    int                   k;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      v = $urandom();
    end else if (k < 7) begin
      v = $urandom_range(0, (1 << $urandom_range(4, 24)) - 1);
      if ($urandom_range(0, 1)) v = -v;
    end else if (k == 7) begin
      v = $urandom_range(0, 1) ? COORD_MAX[CW-1:0] - $urandom_range(0, 255)
                               : COORD_MIN[CW-1:0] + $urandom_range(0, 255);
    end else if (k == 8) begin
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = 32'sh0001_0000;
        2:       v = -32'sh0001_0000;
        default: v = -1;
      endcase
    end else begin
      v = $urandom();
      v = {{4{v[27]}}, v[27:0]};
    end
    return v;
  endfunction

  function automatic point_t random_point();
    point_t pt;
    int     k;
    pt.x = random_coord();
    pt.y = random_coord();
    k    = $urandom_range(0, 9);
    if (k < 5) begin
      pt.ang = $urandom();
    end else if (k < 8) begin
      pt.ang = AW'(($urandom_range(0, 22) - 11) * (QUARTER_STEPS / 2)
                   + $urandom_range(0, 4) - 2);
    end else begin
      pt.ang = AW'($urandom_range(0, 2 * FULL_STEPS) - FULL_STEPS);
    end
    return pt;
  endfunction

  task automatic add_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                           input int ang);
    point_t pt;
    pt.x   = x;
    pt.y   = y;
    pt.ang = AW'(ang);
    points_todo.push_back(pt);
    directed_cnt++;
  endtask

  task automatic wait_drained();
    while (points_todo.size() != 0 || s_axis_tvalid || rotated_due.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("point_rotation_2d_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rotated_due.push_back(predict_rotation(point_on_bus));
        points_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (points_todo.size() > 0) begin
          point_on_bus = points_todo.pop_front();
          s_axis_tdata  <= IN_W'(point_on_bus);
          s_axis_tvalid <= 1'b1;
          gap_left = next_gap(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!hold_done && beats_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = next_gap(recv_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    rotated_t got;
    rotated_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        got.x   = m_axis_tdata[CW-1:0];
        got.y   = m_axis_tdata[2*CW-1:CW];
        got.ovf = m_axis_tuser[0];
        beats_seen++;
        if (rotated_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("%0t: unexpected beat x=%h y=%h ovf=%b", $time, got.x, got.y, got.ovf);
        end else begin
          want = rotated_due.pop_front();
          if (want.ovf) saturated_seen++;
          if (got !== want) begin
            bad_beats++;
            if (bad_beats <= MAX_REPORTS)
              $display("%0t: beat %0d expected x=%h y=%h ovf=%b, got x=%h y=%h ovf=%b",
                       $time, beats_seen, want.x, want.y, want.ovf,
                       got.x, got.y, got.ovf);
          end
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_point(32'sh0001_0000, 32'sh0000_0000, 0);
    add_point(32'sh0001_0000, 32'sh0002_0000, QUARTER_STEPS);
    add_point(32'sh0001_0000, 32'sh0002_0000, 2 * QUARTER_STEPS);
    add_point(32'sh0001_0000, 32'sh0002_0000, 3 * QUARTER_STEPS);
    add_point(32'sh0001_0000, 32'sh0002_0000, -QUARTER_STEPS);
    add_point(32'sh0001_0000, 32'sh0002_0000, FULL_STEPS);
    add_point(32'sh0003_8000, -32'sh0001_4000, QUARTER_STEPS / 2);
    add_point(32'sh0003_8000, -32'sh0001_4000, QUARTER_STEPS / 2 + 1);
    add_point(32'sh0003_8000, -32'sh0001_4000, QUARTER_STEPS / 2 - 1);
    add_point(32'sh0003_8000, -32'sh0001_4000, QUARTER_STEPS - 1);
    add_point(32'sh0100_0000, 32'sh0100_0000, 1);
    add_point(32'sh0100_0000, 32'sh0100_0000, -1);
    add_point(32'sh1234_5678, -32'sh0765_4321, 32767);
    add_point(32'sh1234_5678, -32'sh0765_4321, -32768);
    add_point(COORD_MAX[CW-1:0], COORD_MAX[CW-1:0], QUARTER_STEPS / 2);
    add_point(COORD_MIN[CW-1:0], COORD_MIN[CW-1:0], 2 * QUARTER_STEPS);
    add_point(COORD_MIN[CW-1:0], COORD_MIN[CW-1:0], QUARTER_STEPS / 2);
    add_point(COORD_MIN[CW-1:0], 32'sh0000_0000, 0);
    add_point(COORD_MAX[CW-1:0], COORD_MIN[CW-1:0], 3 * QUARTER_STEPS);
    add_point(COORD_MIN[CW-1:0], COORD_MAX[CW-1:0], QUARTER_STEPS);
    add_point(32'sh0000_0000, 32'sh0000_0000, 12345);
    add_point(-32'sh0000_0001, -32'sh0000_0001, -1);
    wait_drained();

    for (int run = 0; run < RANDOM_RUNS; run++) begin
      for (int i = 0; i < RUN_POINTS; i++)
        points_todo.push_back(random_point());
      wait_drained();
    end

    repeat (4 * PIPE_DEPTH) @(negedge clk_i);
    $display("Rotated %0d points (%0d directed), %0d beats checked, %0d saturated.",
             points_sent, directed_cnt, beats_seen, saturated_seen);
    $display("Input held off for %0d cycles, including one %0d-cycle output stall.",
             input_stall_cycles, HOLD_CYCLES);
    if (bad_beats == 0 && rotated_due.size() == 0) begin
      $display("point_rotation_2d_top regression: pass");
    end else begin
      $display("point_rotation_2d_top regression: fail");
    end
    $finish;
  end

endmodule
